[rtl/core/stpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpe_pkg: shared types and constants of the sparse polynomial evaluator
// Field widths, tdata layout, sequencer states and the multiplier control.
// ----------------------------------------------------------------------------
package stpe_pkg;

    localparam int DATA_W    = 32;          // coefficient, point and sum width
    localparam int EXP_W     = 4;           // width of one exponent field
    localparam int EXP_MAX_F = 15;          // largest value an exponent field holds
    localparam int CFG_IDX_W = 2;

    // Slave tdata layout, lowest bit first
    localparam int COEF_LSB  = 0;
    localparam int EXPX_LSB  = COEF_LSB + DATA_W;
    localparam int EXPY_LSB  = EXPX_LSB + EXP_W;
    localparam int EXPZ_LSB  = EXPY_LSB + EXP_W;
    localparam int IN_USED_W = EXPZ_LSB + EXP_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW_X,
        ST_POW_Y,
        ST_POW_Z,
        ST_ACC
    } stpe_state_t;

    // Control of the shared multiplier
    typedef struct packed {
        logic load;     // take a new coefficient into the product register
        logic step;     // multiply the product register by the operand
    } stpe_mul_ctrl_t;

endpackage : stpe_pkg
`default_nettype wire

[rtl/core/stpe_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpe_mul: shared multiplier with product register
// Holds the running term product and multiplies it by one operand per step,
// keeping the low half (wrap to two's complement).
// ----------------------------------------------------------------------------
module stpe_mul
    import stpe_pkg::*;
(
    input  wire logic               clk,
    input  wire stpe_mul_ctrl_t     ctrl,
    input  wire logic [DATA_W-1:0]  load_value,
    input  wire logic [DATA_W-1:0]  operand,
    output logic      [DATA_W-1:0]  product
);

    logic [DATA_W-1:0]   prod_reg;
    logic [DATA_W-1:0]   prod_next;
    logic [DATA_W-1:0]   low_prod;

    // Low half only: the wrapped product needs no upper bits
    assign low_prod = prod_reg * operand;

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.load)
        begin
            prod_next = load_value;
        end
        else if (ctrl.step)
        begin
            prod_next = low_prod;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule : stpe_mul
`default_nettype wire

[rtl/core/sparse_trivariate_poly_eval_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_trivariate_poly_eval_top: sparse polynomial evaluator in x, y, z
// Takes one term per request and adds coef * x^a * y^b * z^c to a running
// sum; on the last term of a polynomial emits the sum and clears it.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// cfg       in   cfg_we             cfg_index (register), cfg_data (value)
// s_*       in   s_tvalid/s_tready  s_tdata: coefficient, exp x, exp y, exp z
//                                   s_tlast: last term of the polynomial
// m_*       out  m_tvalid/m_tready  m_tdata: polynomial value
//
// A term is worked through the single shared multiplier: one multiply per
// exponent step, exponents taken after clamping to MAX_EXPONENT, plus a step
// to close each variable, one to take the request and one to accumulate. No
// new term is taken until the last one has been accumulated.
// Reset clears the sum, the point registers and the output slot.
// A finished sum waits in the output register; the block keeps taking terms,
// and only holds in the accumulate step if a second sum is due while the
// first has not yet been taken.
// ----------------------------------------------------------------------------
module sparse_trivariate_poly_eval_top
    import stpe_pkg::*;
#(
    parameter int MAX_EXPONENT = 15
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data,
    // term stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [31:0] term_coefficient, [35:32] exponent_x, [39:36] exponent_y,
    // [43:40] exponent_z, [47:44] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,    // last_term
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [DATA_W-1:0]      m_tdata     // [31:0] poly_value
);

    // Exponents saturate at the bound; a field cannot exceed its own range
    localparam int EXP_CAP = (MAX_EXPONENT > EXP_MAX_F) ? EXP_MAX_F : MAX_EXPONENT;
    localparam logic [EXP_W-1:0] EXP_CAP_V = EXP_CAP[EXP_W-1:0];

    function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
        clamp_exp = (e > EXP_CAP_V) ? EXP_CAP_V : e;
    endfunction

    stpe_state_t        state_reg, state_next;
    logic [EXP_W-1:0]   ex_reg, ex_next;
    logic [EXP_W-1:0]   ey_reg, ey_next;
    logic [EXP_W-1:0]   ez_reg, ez_next;
    logic               last_reg, last_next;
    logic [DATA_W-1:0]  sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [DATA_W-1:0]  px_reg, px_next;
    logic [DATA_W-1:0]  py_reg, py_next;
    logic [DATA_W-1:0]  pz_reg, pz_next;

    stpe_mul_ctrl_t     mul_ctrl;
    logic [DATA_W-1:0]  mul_operand;
    logic [DATA_W-1:0]  term_value;
    logic [DATA_W-1:0]  sum_plus;
    logic               in_accept;
    logic               out_free;
    logic               acc_done;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign sum_plus  = sum_reg + term_value;
    // Accumulate step completes unless a sum is due and the slot is still full
    assign acc_done  = (state_reg == ST_ACC) && (!last_reg || out_free);

    stpe_mul u_mul
    (
        .clk        (clk),
        .ctrl       (mul_ctrl),
        .load_value (s_tdata[COEF_LSB +: DATA_W]),
        .operand    (mul_operand),
        .product    (term_value)
    );

    // Next state: walk x, then y, then z powers, then accumulate
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_POW_X;
                end
            end
            ST_POW_X:
            begin
                if (ex_reg == '0)
                begin
                    state_next = ST_POW_Y;
                end
            end
            ST_POW_Y:
            begin
                if (ey_reg == '0)
                begin
                    state_next = ST_POW_Z;
                end
            end
            ST_POW_Z:
            begin
                if (ez_reg == '0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (acc_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and multiplier control
    always_comb
    begin
        s_tready      = 1'b0;
        mul_ctrl.load = 1'b0;
        mul_ctrl.step = 1'b0;
        mul_operand   = px_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                mul_ctrl.load = s_tvalid;
            end
            ST_POW_X:
            begin
                mul_operand   = px_reg;
                mul_ctrl.step = (ex_reg != '0);
            end
            ST_POW_Y:
            begin
                mul_operand   = py_reg;
                mul_ctrl.step = (ey_reg != '0);
            end
            ST_POW_Z:
            begin
                mul_operand   = pz_reg;
                mul_ctrl.step = (ez_reg != '0);
            end
            ST_ACC:
            begin
                mul_operand   = px_reg;
            end
            default:
            begin
                mul_operand   = px_reg;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        ez_next        = ez_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;

        // Drop the result once the sink takes it
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            ex_next   = clamp_exp(s_tdata[EXPX_LSB +: EXP_W]);
            ey_next   = clamp_exp(s_tdata[EXPY_LSB +: EXP_W]);
            ez_next   = clamp_exp(s_tdata[EXPZ_LSB +: EXP_W]);
            last_next = s_tlast;
        end

        // Count down each exponent as its multiply is issued
        if ((state_reg == ST_POW_X) && (ex_reg != '0))
        begin
            ex_next = ex_reg - 1'b1;
        end
        if ((state_reg == ST_POW_Y) && (ey_reg != '0))
        begin
            ey_next = ey_reg - 1'b1;
        end
        if ((state_reg == ST_POW_Z) && (ez_reg != '0))
        begin
            ez_next = ez_reg - 1'b1;
        end

        if (acc_done)
        begin
            if (last_reg)
            begin
                out_data_next  = sum_plus;
                out_valid_next = 1'b1;
                sum_next       = '0;
            end
            else
            begin
                sum_next = sum_plus;
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_POINT_X: px_next = cfg_data;
                REG_POINT_Y: py_next = cfg_data;
                REG_POINT_Z: pz_next = cfg_data;
                default:     px_next = px_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            pz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            pz_reg        <= pz_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        ez_reg       <= ez_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : sparse_trivariate_poly_eval_top
`default_nettype wire

[rtl/core/stpe_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpe_checker: port-level checks for the polynomial evaluator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module stpe_checker
    import stpe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [DATA_W-1:0]      m_tdata
);

    // Hold a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A taken request keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a term was still in work");

    // A new result only appears at the end of a term's work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

endmodule : stpe_checker

bind sparse_trivariate_poly_eval_top stpe_checker u_stpe_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
